// File: hdl/ip4p_pkg.sv
// Shared types and constants for the IPv4 dotted-text parser.
package ip4p_pkg;

    typedef enum logic [1:0] {
        PH_BEFORE = 2'd0,
        PH_DIGITS = 2'd1,
        PH_AFTER  = 2'd2
    } t_phase;

    localparam logic [7:0] CHAR_ZERO = 8'h30;
    localparam logic [7:0] CHAR_NINE = 8'h39;
    localparam logic [7:0] CHAR_DOT  = 8'h2E;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_TAB  = 8'h09;
    localparam logic [7:0] CHAR_CR   = 8'h0D;
    localparam logic [9:0] OCTET_MAX = 10'd255;
    localparam logic [1:0] DOTS_NEEDED_RESET = 2'd3;
    localparam logic [2:0] MAX_OCTETS = 3'd4;
    localparam logic [2:0] MAX_DIGITS = 3'd3;

    function automatic logic is_blank(input logic [7:0] c);
        is_blank = c inside {CHAR_SPACE, [CHAR_TAB:CHAR_CR]};
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        is_digit = c inside {[CHAR_ZERO:CHAR_NINE]};
    endfunction

endpackage

// File: hdl/ip4p_if.sv
// Valid/ready channel interfaces for characters in and parsed addresses out.
interface ip4p_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_code;
    logic       end_mark;

    modport source (output valid, output char_code, output end_mark, input ready);
    modport sink   (input valid, input char_code, input end_mark, output ready);
endinterface

interface ip4p_res_if;
    logic        valid;
    logic        ready;
    logic [31:0] address;
    logic        valid_res;

    modport source (output valid, output address, output valid_res, input ready);
    modport sink   (input valid, input address, input valid_res, output ready);
endinterface

// File: hdl/ipv4_dotted_text_parser_top.sv
// IPv4 dotted-decimal text parser: input register, parse state, two-entry result queue.
// Throughput: one character word per cycle, end words included, while results drain.
// The result word for an end word passes the input register, then the result queue
// register, before it is offered on o_res.
// Input stalls only when both result queue slots are taken or reserved.
// Reset (i_rst_n low, synchronous): parse state and queue clear, dot count goes back to 3.
module ipv4_dotted_text_parser_top (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_wr_en,
    input  logic [1:0]        i_cfg_wr_data,
    ip4p_char_if.sink         i_char,
    ip4p_res_if.source        o_res
);

    // configuration
    logic [1:0] r_dots_needed;

    // input register
    logic       r_in_valid;
    logic [7:0] r_in_char;
    logic       r_in_end;

    // parse state
    logic [31:0]          r_addr, n_addr;
    logic [9:0]           r_oct, n_oct;
    logic [2:0]           r_dcnt, n_dcnt;
    ip4p_pkg::t_phase     r_phase, n_phase;
    logic [2:0]           r_ocnt, n_ocnt;
    logic                 r_err, n_err;

    // result queue
    logic [1:0]  r_cnt, n_cnt;
    logic [31:0] r_q0_addr, n_q0_addr, r_q1_addr, n_q1_addr;
    logic        r_q0_vr, n_q0_vr, r_q1_vr, n_q1_vr;

    logic        in_acc, push, pop;
    logic [1:0]  occ;
    logic        close_ok;
    logic [31:0] closed_addr;
    logic [2:0]  closed_ocnt;
    logic        end_err;
    logic        res_ok;
    logic [31:0] res_addr;
    logic [9:0]  oct_next;

    // a slot is held for an end word sitting in the input register
    assign occ      = r_cnt + {1'b0, r_in_valid & r_in_end} - {1'b0, pop};
    assign pop      = r_cnt != 2'd0 && o_res.ready;
    assign i_char.ready = occ < 2'd2;
    assign in_acc   = i_char.valid && i_char.ready;
    assign push     = r_in_valid && r_in_end;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dots_needed <= ip4p_pkg::DOTS_NEEDED_RESET;
        end else if (i_cfg_wr_en) begin
            r_dots_needed <= i_cfg_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= in_acc;
        end
        if (in_acc) begin
            r_in_char <= i_char.char_code;
            r_in_end  <= i_char.end_mark;
        end
    end

    // closing the open octet
    always_comb begin
        close_ok    = !r_err && r_ocnt < ip4p_pkg::MAX_OCTETS && r_dcnt != 3'd0
                      && r_oct <= ip4p_pkg::OCTET_MAX;
        closed_ocnt = r_ocnt + 3'd1;
        closed_addr = r_addr;
        case (r_ocnt[1:0])
            2'd0:    closed_addr[31:24] = r_oct[7:0];
            2'd1:    closed_addr[23:16] = r_oct[7:0];
            2'd2:    closed_addr[15:8]  = r_oct[7:0];
            default: closed_addr[7:0]   = r_oct[7:0];
        endcase
        oct_next = (r_oct << 3) + (r_oct << 1) + {6'd0, r_in_char[3:0]};
    end

    always_comb begin
        end_err  = r_err || !close_ok;
        res_ok   = !end_err && closed_ocnt >= ({1'b0, r_dots_needed} + 3'd1);
        res_addr = res_ok ? closed_addr : 32'd0;
    end

    // parse state next value
    always_comb begin
        n_addr  = r_addr;
        n_oct   = r_oct;
        n_dcnt  = r_dcnt;
        n_phase = r_phase;
        n_ocnt  = r_ocnt;
        n_err   = r_err;
        if (r_in_valid) begin
            if (r_in_end) begin
                n_addr  = 32'd0;
                n_oct   = 10'd0;
                n_dcnt  = 3'd0;
                n_phase = ip4p_pkg::PH_BEFORE;
                n_ocnt  = 3'd0;
                n_err   = 1'b0;
            end else if (!r_err) begin
                if (r_in_char == ip4p_pkg::CHAR_DOT) begin
                    if (close_ok) begin
                        n_addr  = closed_addr;
                        n_ocnt  = closed_ocnt;
                        n_oct   = 10'd0;
                        n_dcnt  = 3'd0;
                        n_phase = ip4p_pkg::PH_BEFORE;
                    end else begin
                        n_err = 1'b1;
                    end
                end else if (ip4p_pkg::is_blank(r_in_char)) begin
                    if (r_phase == ip4p_pkg::PH_DIGITS) begin
                        n_phase = ip4p_pkg::PH_AFTER;
                    end
                end else if (ip4p_pkg::is_digit(r_in_char)) begin
                    if (r_phase == ip4p_pkg::PH_AFTER || r_dcnt >= ip4p_pkg::MAX_DIGITS) begin
                        n_err = 1'b1;
                    end else begin
                        n_oct   = oct_next;
                        n_dcnt  = r_dcnt + 3'd1;
                        n_phase = ip4p_pkg::PH_DIGITS;
                    end
                end else begin
                    n_err = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_addr  <= 32'd0;
            r_oct   <= 10'd0;
            r_dcnt  <= 3'd0;
            r_phase <= ip4p_pkg::PH_BEFORE;
            r_ocnt  <= 3'd0;
            r_err   <= 1'b0;
        end else begin
            r_addr  <= n_addr;
            r_oct   <= n_oct;
            r_dcnt  <= n_dcnt;
            r_phase <= n_phase;
            r_ocnt  <= n_ocnt;
            r_err   <= n_err;
        end
    end

    // two-entry result queue, slot 0 is the head
    always_comb begin
        n_cnt     = r_cnt;
        n_q0_addr = r_q0_addr;
        n_q0_vr   = r_q0_vr;
        n_q1_addr = r_q1_addr;
        n_q1_vr   = r_q1_vr;
        if (pop) begin
            n_q0_addr = r_q1_addr;
            n_q0_vr   = r_q1_vr;
        end
        if (push) begin
            if ((r_cnt == 2'd0) || (r_cnt == 2'd1 && pop)) begin
                n_q0_addr = res_addr;
                n_q0_vr   = res_ok;
            end else begin
                n_q1_addr = res_addr;
                n_q1_vr   = res_ok;
            end
        end
        n_cnt = r_cnt + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
        end
        r_q0_addr <= n_q0_addr;
        r_q0_vr   <= n_q0_vr;
        r_q1_addr <= n_q1_addr;
        r_q1_vr   <= n_q1_vr;
    end

    assign o_res.valid     = r_cnt != 2'd0;
    assign o_res.address   = r_q0_addr;
    assign o_res.valid_res = r_q0_vr;

`ifndef SYNTH
    a_queue_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= 2'd2)
        else $error("result queue overflow");

    a_end_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && r_in_end |=> !r_err && r_ocnt == 3'd0 && r_dcnt == 3'd0)
        else $error("parse state not cleared after end word");

    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && !o_res.valid_res |-> o_res.address == 32'd0)
        else $error("invalid result carries nonzero address");

    a_octet_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ocnt <= ip4p_pkg::MAX_OCTETS && r_dcnt <= ip4p_pkg::MAX_DIGITS)
        else $error("octet or digit count out of range");

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push && r_cnt == 2'd2 |-> pop)
        else $error("result pushed into full queue");
`endif

endmodule
